[src/lzd_pkg.sv]
// ----------------------------------------------------------------------------
// LZ77 bit-packed decoder package
// Shared result kinds, header constants and the handshake structs that pass
// between the token sequencer and the result queue.
// ----------------------------------------------------------------------------
package lzd_pkg;

    // Result kinds carried on the output tuser field.
    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_HDR_ERR = 2'd1,
        KIND_OFF_ERR = 2'd2,
        KIND_END     = 2'd3
    } t_kind;

    // First header byte: the flag-mode bit and the offset width field.
    localparam int unsigned HDR_FLAG_BIT   = 7;
    localparam logic [6:0]  HDR_WIDTH_MASK = 7'h7F;

    // Largest offset width that any build may be configured for.
    localparam int unsigned OFFSET_BITS_LIMIT = 24;

    // Literal width in bits.
    localparam int unsigned LIT_BITS = 8;

    // Request from the sequencer: one result, or the end of the current input byte.
    typedef struct packed {
        logic        valid;
        logic        done;
        t_kind       kind;
        logic [7:0]  data;
    } t_emit;

    // Answer from the result queue: which request may complete this cycle.
    typedef struct packed {
        logic emit_ok;
        logic done_ok;
    } t_sink;

endpackage

[src/lzd_history.sv]
// ----------------------------------------------------------------------------
// History store
// Single-port-write, single-port-read memory of previously produced bytes,
// with registered read data.
// ----------------------------------------------------------------------------
module lzd_history #(
    parameter int unsigned DEPTH,
    parameter int unsigned AW
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/lzd_outq.sv]
// ----------------------------------------------------------------------------
// Result queue
// Holds the newest result back by one so that the last result of an input
// byte can be marked once the sequencer reports that the byte is finished,
// and drives the output register.
// ----------------------------------------------------------------------------
module lzd_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lzd_pkg::t_emit     i_emit,
    output lzd_pkg::t_sink     o_sink,
    output logic               o_valid,
    input  logic               i_ready,
    output lzd_pkg::t_kind     o_kind,
    output logic [7:0]         o_data,
    output logic               o_last
);

    logic            r_p_valid, n_p_valid;
    lzd_pkg::t_kind  r_p_kind, n_p_kind;
    logic [7:0]      r_p_data, n_p_data;
    logic            r_o_valid, n_o_valid;
    lzd_pkg::t_kind  r_o_kind, n_o_kind;
    logic [7:0]      r_o_data, n_o_data;
    logic            r_o_last, n_o_last;
    logic            out_free;
    logic            slot_ok;
    logic            emit_fire;
    logic            done_fire;

    // The pending slot may move on whenever the output register is free.
    assign out_free  = !r_o_valid || i_ready;
    assign slot_ok   = !r_p_valid || out_free;
    assign emit_fire = i_emit.valid && slot_ok;
    assign done_fire = i_emit.done && slot_ok;

    assign o_sink.emit_ok = slot_ok;
    assign o_sink.done_ok = slot_ok;

    // Next state of the pending slot and the output register.
    always_comb begin
        n_p_valid = r_p_valid;
        n_p_kind  = r_p_kind;
        n_p_data  = r_p_data;
        n_o_valid = r_o_valid;
        n_o_kind  = r_o_kind;
        n_o_data  = r_o_data;
        n_o_last  = r_o_last;
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end
        if ((emit_fire || done_fire) && r_p_valid) begin
            n_o_valid = 1'b1;
            n_o_kind  = r_p_kind;
            n_o_data  = r_p_data;
            n_o_last  = done_fire;
        end
        if (emit_fire) begin
            n_p_valid = 1'b1;
            n_p_kind  = i_emit.kind;
            n_p_data  = i_emit.data;
        end else if (done_fire) begin
            n_p_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_p_valid <= n_p_valid;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_p_kind <= n_p_kind;
        r_p_data <= n_p_data;
        r_o_kind <= n_o_kind;
        r_o_data <= n_o_data;
        r_o_last <= n_o_last;
    end

    assign o_valid = r_o_valid;
    assign o_kind  = r_o_kind;
    assign o_data  = r_o_data;
    assign o_last  = r_o_last;

    // The sequencer never reports a result and the end of a byte together.
    a_emit_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_emit.valid && i_emit.done))
        else $error("result and end of byte requested together");

    // Finishing a byte with a result held back sends that result out marked last.
    a_done_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done_fire && r_p_valid) |=> (r_o_valid && r_o_last && !r_p_valid))
        else $error("last result of a byte not marked");

    // Finishing a byte always empties the pending slot.
    a_done_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_fire |=> !r_p_valid)
        else $error("pending result left behind after end of byte");

    // Only data results carry a byte value.
    a_nondata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_kind != lzd_pkg::KIND_DATA) |-> (r_o_data == 8'd0))
        else $error("non-data result carries a byte value");

endmodule

[src/lzd_seq.sv]
// ----------------------------------------------------------------------------
// Token sequencer
// Parses the header, gathers body bits LSB-first and decodes one token step
// per cycle unless the result queue stalls it, with a single shift-and-mask
// extractor; each copied byte is read from the history store, then written and sent.
// ----------------------------------------------------------------------------
module lzd_seq #(
    parameter int unsigned DEPTH,
    parameter int unsigned AW,
    parameter int unsigned MAX_OFFSET_BITS,
    parameter int unsigned MAX_LENGTH_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_byte,
    input  logic            i_eos,
    output lzd_pkg::t_emit  o_emit,
    input  lzd_pkg::t_sink  i_sink,
    output logic            o_hist_we,
    output logic [AW-1:0]   o_hist_waddr,
    output logic [7:0]      o_hist_wdata,
    output logic            o_hist_re,
    output logic [AW-1:0]   o_hist_raddr,
    input  logic [7:0]      i_hist_rdata
);

    // The accumulator never holds a full token plus a whole byte.
    localparam int unsigned ACC_W = MAX_OFFSET_BITS + MAX_LENGTH_BITS + 7;
    localparam int unsigned HW    = $clog2(ACC_W + 1);
    localparam int unsigned LWW   = $clog2(MAX_LENGTH_BITS + 1);
    localparam int unsigned PC_W  = $clog2(DEPTH + 1);
    localparam int unsigned CMP_W = (MAX_OFFSET_BITS > PC_W) ? MAX_OFFSET_BITS : PC_W;
    localparam int unsigned IW    = PC_W + 1;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DEC  = 7'b0000010,
        ST_HERR = 7'b0000100,
        ST_CRD  = 7'b0001000,
        ST_CWR  = 7'b0010000,
        ST_EOS  = 7'b0100000,
        ST_DONE = 7'b1000000
    } t_state;

    typedef enum logic [3:0] {
        PH_HDR0 = 4'b0001,
        PH_HDR1 = 4'b0010,
        PH_BODY = 4'b0100,
        PH_DROP = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        TS_START = 3'b001,
        TS_LIT   = 3'b010,
        TS_COPY  = 3'b100
    } t_stage;

    t_state                     r_state, n_state;
    t_phase                     r_phase, n_phase;
    t_stage                     r_stage, n_stage;
    logic                       r_flag, n_flag;
    logic [6:0]                 r_ow, n_ow;
    logic [LWW-1:0]             r_lw, n_lw;
    logic [ACC_W-1:0]           r_acc, n_acc;
    logic [HW-1:0]              r_held, n_held;
    logic [MAX_LENGTH_BITS-1:0] r_lits, n_lits;
    logic [AW-1:0]              r_wp, n_wp;
    logic [PC_W-1:0]            r_pc, n_pc;
    logic [PC_W-1:0]            r_off, n_off;
    logic [MAX_LENGTH_BITS-1:0] r_len, n_len;
    logic                       r_last, n_last;

    // Token field extractor, shared by every offset and length decode step.
    logic [MAX_OFFSET_BITS-1:0] off_v;
    logic [ACC_W-1:0]           acc_sh_ow;
    logic [MAX_LENGTH_BITS-1:0] len_v;
    logic [HW-1:0]              tok;
    logic                       off_bad;
    logic [MAX_LENGTH_BITS-1:0] lits_dec;
    logic                       hdr_bad;
    logic [IW-1:0]              wp_e;
    logic [IW-1:0]              off_e;
    logic [IW-1:0]              idx_e;
    logic [AW-1:0]              wp_inc;
    logic [PC_W-1:0]            pc_inc;
    t_state                     fin_in;
    t_state                     fin_reg;

    assign off_v     = r_acc[MAX_OFFSET_BITS-1:0] & ~({MAX_OFFSET_BITS{1'b1}} << r_ow);
    assign acc_sh_ow = r_acc >> r_ow;
    assign len_v     = acc_sh_ow[MAX_LENGTH_BITS-1:0] & ~({MAX_LENGTH_BITS{1'b1}} << r_lw);
    assign tok       = HW'(r_ow) + HW'(r_lw);
    assign off_bad   = (off_v == '0) || (CMP_W'(off_v) > CMP_W'(r_pc));
    assign lits_dec  = (r_lits != '0) ? r_lits - 1'b1 : r_lits;

    // Header width check, made as the second header byte arrives.
    assign hdr_bad = (r_ow == 7'd0) || (r_ow > 7'(MAX_OFFSET_BITS)) ||
                     (i_byte == 8'd0) || (i_byte > 8'(MAX_LENGTH_BITS));

    // Circular history addressing.
    assign wp_e   = IW'(r_wp);
    assign off_e  = IW'(r_off);
    assign idx_e  = (wp_e >= off_e) ? (wp_e - off_e) : (wp_e + IW'(DEPTH) - off_e);
    assign wp_inc = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign pc_inc = (r_pc < PC_W'(DEPTH)) ? r_pc + 1'b1 : r_pc;

    // Where a byte's work ends: with the end-of-stream result or straight to done.
    assign fin_in  = i_eos ? ST_EOS : ST_DONE;
    assign fin_reg = r_last ? ST_EOS : ST_DONE;

    assign o_ready = (r_state == ST_IDLE);

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_stage      = r_stage;
        n_flag       = r_flag;
        n_ow         = r_ow;
        n_lw         = r_lw;
        n_acc        = r_acc;
        n_held       = r_held;
        n_lits       = r_lits;
        n_wp         = r_wp;
        n_pc         = r_pc;
        n_off        = r_off;
        n_len        = r_len;
        n_last       = r_last;
        o_emit       = '0;
        o_hist_we    = 1'b0;
        o_hist_waddr = r_wp;
        o_hist_wdata = '0;
        o_hist_re    = 1'b0;
        o_hist_raddr = AW'(idx_e);

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_last = i_eos;
                    unique case (r_phase)
                        PH_HDR0: begin
                            n_ow    = i_byte[6:0] & lzd_pkg::HDR_WIDTH_MASK;
                            n_flag  = i_byte[lzd_pkg::HDR_FLAG_BIT];
                            n_phase = PH_HDR1;
                            n_state = fin_in;
                        end
                        PH_HDR1: begin
                            if (hdr_bad) begin
                                n_ow    = '0;
                                n_lw    = '0;
                                n_phase = PH_DROP;
                                n_state = ST_HERR;
                            end else begin
                                n_lw    = i_byte[LWW-1:0];
                                n_phase = PH_BODY;
                                n_state = fin_in;
                            end
                        end
                        PH_BODY: begin
                            n_acc   = r_acc | ({{(ACC_W-8){1'b0}}, i_byte} << r_held);
                            n_held  = r_held + HW'(lzd_pkg::LIT_BITS);
                            n_state = ST_DEC;
                        end
                        PH_DROP: begin
                            n_state = fin_in;
                        end
                        default: begin
                            n_state = fin_in;
                        end
                    endcase
                end
            end

            ST_HERR: begin
                o_emit.valid = 1'b1;
                o_emit.kind  = lzd_pkg::KIND_HDR_ERR;
                if (i_sink.emit_ok) begin
                    n_state = fin_reg;
                end
            end

            ST_DEC: begin
                if (r_stage == TS_LIT) begin
                    // One literal byte.
                    if (r_held < HW'(lzd_pkg::LIT_BITS)) begin
                        n_state = fin_reg;
                    end else begin
                        o_emit.valid = 1'b1;
                        o_emit.kind  = lzd_pkg::KIND_DATA;
                        o_emit.data  = r_acc[7:0];
                        if (i_sink.emit_ok) begin
                            o_hist_we    = 1'b1;
                            o_hist_wdata = r_acc[7:0];
                            n_wp         = wp_inc;
                            n_pc         = pc_inc;
                            n_acc        = r_acc >> lzd_pkg::LIT_BITS;
                            n_held       = r_held - HW'(lzd_pkg::LIT_BITS);
                            if (r_flag) begin
                                n_stage = TS_START;
                            end else begin
                                n_lits = lits_dec;
                                if (lits_dec == '0) begin
                                    n_stage = TS_START;
                                end
                            end
                        end
                    end
                end else if (r_flag && r_stage == TS_START) begin
                    // Flag bit of a flag-mode token.
                    if (r_held == '0) begin
                        n_state = fin_reg;
                    end else begin
                        n_stage = r_acc[0] ? TS_LIT : TS_COPY;
                        n_acc   = r_acc >> 1;
                        n_held  = r_held - 1'b1;
                    end
                end else begin
                    // Offset and length fields.
                    if (r_held < tok) begin
                        n_state = fin_reg;
                    end else if (!r_flag && off_v == '0) begin
                        n_acc  = r_acc >> tok;
                        n_held = r_held - tok;
                        if (len_v != '0) begin
                            n_lits  = len_v;
                            n_stage = TS_LIT;
                        end else begin
                            n_stage = TS_START;
                        end
                    end else if (off_bad) begin
                        o_emit.valid = 1'b1;
                        o_emit.kind  = lzd_pkg::KIND_OFF_ERR;
                        if (i_sink.emit_ok) begin
                            n_acc   = r_acc >> tok;
                            n_held  = r_held - tok;
                            n_stage = TS_START;
                            n_phase = PH_DROP;
                            n_state = fin_reg;
                        end
                    end else begin
                        n_acc   = r_acc >> tok;
                        n_held  = r_held - tok;
                        n_stage = TS_START;
                        if (len_v != '0) begin
                            n_off   = PC_W'(off_v);
                            n_len   = len_v;
                            n_state = ST_CRD;
                        end
                    end
                end
            end

            ST_CRD: begin
                o_hist_re = 1'b1;
                n_state   = ST_CWR;
            end

            ST_CWR: begin
                o_emit.valid = 1'b1;
                o_emit.kind  = lzd_pkg::KIND_DATA;
                o_emit.data  = i_hist_rdata;
                if (i_sink.emit_ok) begin
                    o_hist_we    = 1'b1;
                    o_hist_wdata = i_hist_rdata;
                    n_wp         = wp_inc;
                    n_pc         = pc_inc;
                    n_len        = r_len - 1'b1;
                    n_state      = (r_len == MAX_LENGTH_BITS'(1)) ? ST_DEC : ST_CRD;
                end
            end

            ST_EOS: begin
                o_emit.valid = 1'b1;
                o_emit.kind  = lzd_pkg::KIND_END;
                if (i_sink.emit_ok) begin
                    n_phase = PH_HDR0;
                    n_stage = TS_START;
                    n_flag  = 1'b0;
                    n_ow    = '0;
                    n_lw    = '0;
                    n_acc   = '0;
                    n_held  = '0;
                    n_lits  = '0;
                    n_wp    = '0;
                    n_pc    = '0;
                    n_state = ST_DONE;
                end
            end

            ST_DONE: begin
                o_emit.done = 1'b1;
                if (i_sink.done_ok) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Stream and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_HDR0;
            r_stage <= TS_START;
            r_flag  <= 1'b0;
            r_ow    <= '0;
            r_lw    <= '0;
            r_acc   <= '0;
            r_held  <= '0;
            r_lits  <= '0;
            r_wp    <= '0;
            r_pc    <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_stage <= n_stage;
            r_flag  <= n_flag;
            r_ow    <= n_ow;
            r_lw    <= n_lw;
            r_acc   <= n_acc;
            r_held  <= n_held;
            r_lits  <= n_lits;
            r_wp    <= n_wp;
            r_pc    <= n_pc;
            r_last  <= n_last;
        end
    end

    // Copy operands.
    always_ff @(posedge i_clk) begin
        r_off <= n_off;
        r_len <= n_len;
    end

endmodule

[src/lz77_bitpacked_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// LZ77 bit-packed stream decoder
// Takes a compressed stream a byte at a time and returns the decompressed
// bytes, header and offset errors, and an end marker for every stream.
//
// Channel  Dir  tdata              tuser      tlast
// s_axis   in   [7:0] in_byte      -          end_of_stream
// m_axis   out  [7:0] out_byte     [1:0] kind last_of_run
//
// A byte is taken while the sequencer is idle. The sequencer then works through
// each token step, reads every copied byte from the history and then writes and
// sends it, sends each literal, error or end result, and closes the byte.
// Reset is synchronous and active low; the history store needs no clearing.
// A stalled output holds the sequencer at its next result.
// ----------------------------------------------------------------------------
module lz77_bitpacked_stream_decoder_unit #(
    parameter int unsigned HISTORY_DEPTH   = 4096,
    parameter int unsigned MAX_OFFSET_BITS = 12,
    parameter int unsigned MAX_LENGTH_BITS = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast
);

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);

    lzd_pkg::t_emit emit;
    lzd_pkg::t_sink sink;
    lzd_pkg::t_kind out_kind;
    logic           hist_we;
    logic [AW-1:0]  hist_waddr;
    logic [7:0]     hist_wdata;
    logic           hist_re;
    logic [AW-1:0]  hist_raddr;
    logic [7:0]     hist_rdata;

    // Header parsing and token decoding.
    lzd_seq #(
        .DEPTH           (HISTORY_DEPTH),
        .AW              (AW),
        .MAX_OFFSET_BITS (MAX_OFFSET_BITS),
        .MAX_LENGTH_BITS (MAX_LENGTH_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_eos        (s_axis_tlast),
        .o_emit       (emit),
        .i_sink       (sink),
        .o_hist_we    (hist_we),
        .o_hist_waddr (hist_waddr),
        .o_hist_wdata (hist_wdata),
        .o_hist_re    (hist_re),
        .o_hist_raddr (hist_raddr),
        .i_hist_rdata (hist_rdata)
    );

    // Window of produced bytes for copies.
    lzd_history #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_re    (hist_re),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    // Result marking and output register.
    lzd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_sink  (sink),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (out_kind),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;

endmodule

[tb/lz77_decoder_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ77 decoder stream checker
// Watches the compressed input channel and the decoded output channel of the
// decoder. It decodes every accepted input byte with its own copy of the
// header, bit buffer and history, queues the results that byte must cause,
// and compares each output transaction field by field with the oldest one.
// ----------------------------------------------------------------------------
module lz77_decoder_stream_checker #(
    parameter int unsigned HISTORY_DEPTH   = 4096,
    parameter int unsigned MAX_OFFSET_BITS = 12,
    parameter int unsigned MAX_LENGTH_BITS = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_data,      // [7:0] in_byte
    input  logic       i_in_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_data,     // [7:0] out_byte
    input  logic [1:0] i_out_kind,     // [1:0] kind
    input  logic       i_out_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_result_count,
    output int         o_error_count
);

    // No single input byte may cause more results than this.
    localparam int unsigned RESULT_CAP = 64;

    typedef enum logic [1:0] {
        PH_HEADER_FIRST  = 2'd0,
        PH_HEADER_SECOND = 2'd1,
        PH_BODY          = 2'd2,
        PH_DROPPING      = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        TS_START       = 2'd0,
        TS_LITERAL     = 2'd1,
        TS_COPY_FIELDS = 2'd2
    } t_stage;

    typedef struct packed {
        lzd_pkg::t_kind kind;
        logic [7:0]     data;
        logic           last;
    } t_decoded;

    // Results still owed by the decoder, oldest first.
    t_decoded    owed_q[$];
    // Results of the byte being decoded, before the last one is marked.
    t_decoded    byte_q[$];

    // Stream state as the decoder should hold it.
    t_phase      phase;
    t_stage      stage;
    logic [6:0]  offset_width;
    logic [7:0]  length_width;
    logic        flag_mode;
    logic [63:0] bit_buffer;
    int unsigned bits_held;
    int unsigned literals_left;
    logic [7:0]  history [0:HISTORY_DEPTH-1];
    int unsigned write_ptr;
    int unsigned produced;

    function automatic void queue_result(input lzd_pkg::t_kind kind, input logic [7:0] data);
        t_decoded r;
        if (byte_q.size() < RESULT_CAP) begin
            r.kind = kind;
            r.data = data;
            r.last = 1'b0;
            byte_q = {byte_q, r};
        end
    endfunction

    // Fields leave the bit buffer from its lowest bit.
    function automatic logic [63:0] pull_bits(input int unsigned count);
        logic [63:0] v;
        v = bit_buffer & ((64'd1 << count) - 64'd1);
        bit_buffer = bit_buffer >> count;
        bits_held = bits_held - count;
        return v;
    endfunction

    function automatic void write_output(input logic [7:0] data);
        history[write_ptr] = data;
        write_ptr = (write_ptr + 1 == HISTORY_DEPTH) ? 0 : write_ptr + 1;
        if (produced < HISTORY_DEPTH) produced++;
        queue_result(lzd_pkg::KIND_DATA, data);
    endfunction

    function automatic void reset_stream();
        phase         = PH_HEADER_FIRST;
        stage         = TS_START;
        offset_width  = '0;
        length_width  = '0;
        flag_mode     = 1'b0;
        bit_buffer    = '0;
        bits_held     = 0;
        literals_left = 0;
        write_ptr     = 0;
        produced      = 0;
    endfunction

    // A copy may overlap its own output, so it reads back one byte at a time.
    function automatic bit copy_history(input int unsigned distance, input int unsigned count);
        int unsigned k;
        int unsigned src;
        if (distance == 0 || distance > produced) begin
            queue_result(lzd_pkg::KIND_OFF_ERR, 8'h00);
            phase = PH_DROPPING;
            return 1'b0;
        end
        for (k = 0; k < count; k++) begin
            src = (write_ptr >= distance) ? write_ptr - distance
                                          : write_ptr + HISTORY_DEPTH - distance;
            write_output(history[src]);
        end
        return 1'b1;
    endfunction

    // Decodes every token that the bit buffer now holds completely.
    function automatic void decode_tokens();
        int unsigned token_bits;
        int unsigned distance;
        int unsigned count;
        logic [63:0] field;
        bit          running;
        token_bits = offset_width + length_width;
        running    = 1'b1;
        while (running) begin
            if (stage == TS_LITERAL) begin
                if (bits_held < lzd_pkg::LIT_BITS) begin
                    running = 1'b0;
                end else begin
                    field = pull_bits(lzd_pkg::LIT_BITS);
                    write_output(field[7:0]);
                    if (flag_mode) begin
                        stage = TS_START;
                    end else begin
                        if (literals_left > 0) literals_left--;
                        if (literals_left == 0) stage = TS_START;
                    end
                end
            end else if (flag_mode && stage == TS_START) begin
                if (bits_held < 1) begin
                    running = 1'b0;
                end else begin
                    field = pull_bits(1);
                    stage = field[0] ? TS_LITERAL : TS_COPY_FIELDS;
                end
            end else if (bits_held < token_bits) begin
                running = 1'b0;
            end else begin
                field    = pull_bits(offset_width);
                distance = field[31:0];
                field    = pull_bits(length_width);
                count    = field[31:0];
                if (!flag_mode && distance == 0) begin
                    // Offset zero in run mode opens a run of literals.
                    literals_left = count;
                    stage = (count > 0) ? TS_LITERAL : TS_START;
                end else begin
                    stage = TS_START;
                    if (!copy_history(distance, count)) running = 1'b0;
                end
            end
        end
    endfunction

    // Works out every result that one accepted input byte causes.
    function automatic void decode_byte(input logic [7:0] data, input logic stream_end);
        int unsigned i;
        t_decoded    r;
        byte_q.delete();
        case (phase)
            PH_HEADER_FIRST: begin
                offset_width = data[6:0] & lzd_pkg::HDR_WIDTH_MASK;
                flag_mode    = data[lzd_pkg::HDR_FLAG_BIT];
                phase        = PH_HEADER_SECOND;
            end
            PH_HEADER_SECOND: begin
                length_width = data;
                if (offset_width < 1 || offset_width > MAX_OFFSET_BITS ||
                    length_width < 1 || length_width > MAX_LENGTH_BITS) begin
                    queue_result(lzd_pkg::KIND_HDR_ERR, 8'h00);
                    offset_width = '0;
                    length_width = '0;
                    phase        = PH_DROPPING;
                end else begin
                    phase = PH_BODY;
                end
            end
            PH_BODY: begin
                bit_buffer = bit_buffer | ({56'd0, data} << bits_held);
                bits_held  = bits_held + 8;
                decode_tokens();
            end
            default: begin
            end
        endcase
        if (stream_end) begin
            queue_result(lzd_pkg::KIND_END, 8'h00);
            reset_stream();
        end
        for (i = 0; i < byte_q.size(); i++) begin
            r      = byte_q[i];
            r.last = (i == byte_q.size() - 1);
            owed_q = {owed_q, r};
        end
    endfunction

    // Predict on input transactions, compare on output transactions.
    always @(posedge i_clk) begin : compare_results
        t_decoded want;
        logic     bad;
        if (!i_rst_n) begin
            owed_q.delete();
            reset_stream();
            o_fail_count   <= 0;
            o_result_count <= 0;
            o_error_count  <= 0;
        end else begin
            if (i_in_valid && i_in_ready) decode_byte(i_in_data, i_in_last);
            if (i_out_valid && i_out_ready) begin
                o_result_count <= o_result_count + 1;
                if (i_out_kind == lzd_pkg::KIND_HDR_ERR || i_out_kind == lzd_pkg::KIND_OFF_ERR)
                    o_error_count <= o_error_count + 1;
                if (owed_q.size() == 0) begin
                    $display("%0t: result with none owed: kind %0d, byte 0x%02h, last %0b",
                             $time, i_out_kind, i_out_data, i_out_last);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = owed_q.pop_front();
                    bad  = 1'b0;
                    if (i_out_kind !== want.kind) begin
                        $display("%0t: kind expected %0d, actual %0d",
                                 $time, want.kind, i_out_kind);
                        bad = 1'b1;
                    end
                    if (i_out_data !== want.data) begin
                        $display("%0t: out_byte expected 0x%02h, actual 0x%02h",
                                 $time, want.data, i_out_data);
                        bad = 1'b1;
                    end
                    if (i_out_last !== want.last) begin
                        $display("%0t: last_of_run expected %0b, actual %0b",
                                 $time, want.last, i_out_last);
                        bad = 1'b1;
                    end
                    if (bad) o_fail_count <= o_fail_count + 1;
                end
            end
        end
        o_pending <= owed_q.size();
    end

endmodule

[tb/lz77_bitpacked_stream_decoder_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ77 bit-packed stream decoder test
// Builds compressed streams bit by bit and feeds them to the decoder in
// bursts, while the output side stalls on its own pattern and once holds off
// for a long stretch. A directed set of short streams covers the header
// limits, both token modes, overlapping copies and every error; random
// streams follow. The checker beside the decoder reports the mismatches.
// ----------------------------------------------------------------------------
module lz77_bitpacked_stream_decoder_unit_test;

    localparam int unsigned HISTORY_DEPTH   = 4096;
    localparam int unsigned MAX_OFFSET_BITS = 12;
    localparam int unsigned MAX_LENGTH_BITS = 5;
    localparam int unsigned CLK_PERIOD      = 10;
    localparam int unsigned RANDOM_BYTES    = 200;
    localparam int unsigned HOLD_OFF_START  = 600;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned SETTLE_CYCLES   = 64;
    localparam int unsigned CYCLE_LIMIT     = 1000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] in_byte
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic [1:0] m_axis_tuser;   // [1:0] kind
    logic       m_axis_tlast;

    int fail_count;
    int pending;
    int result_count;
    int error_count;

    lz77_bitpacked_stream_decoder_unit #(
        .HISTORY_DEPTH  (HISTORY_DEPTH),
        .MAX_OFFSET_BITS(MAX_OFFSET_BITS),
        .MAX_LENGTH_BITS(MAX_LENGTH_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    lz77_decoder_stream_checker #(
        .HISTORY_DEPTH  (HISTORY_DEPTH),
        .MAX_OFFSET_BITS(MAX_OFFSET_BITS),
        .MAX_LENGTH_BITS(MAX_LENGTH_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_last     (s_axis_tlast),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_kind    (m_axis_tuser),
        .i_out_last    (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count),
        .o_error_count (error_count)
    );

    // Clock.
    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Stream under construction: bytes so far and the partly filled byte.
    logic [7:0]  stream_q[$];
    logic [7:0]  pack_byte;
    int unsigned pack_bits;
    int unsigned decoded_so_far;
    int unsigned burst_left;
    int unsigned streams_sent;
    int unsigned bytes_sent;

    // Appends one byte to the stream under construction.
    function automatic void append_byte(input logic [7:0] data);
        stream_q = {stream_q, data};
    endfunction

    function automatic void open_stream(input logic [7:0] first, input logic [7:0] second);
        stream_q.delete();
        append_byte(first);
        append_byte(second);
        pack_byte      = 8'h00;
        pack_bits      = 0;
        decoded_so_far = 0;
    endfunction

    // Fields go into the stream from their lowest bit.
    function automatic void put_field(input int unsigned value, input int unsigned width);
        int unsigned i;
        for (i = 0; i < width; i++) begin
            pack_byte[pack_bits] = value[i];
            pack_bits++;
            if (pack_bits == 8) begin
                append_byte(pack_byte);
                pack_byte = 8'h00;
                pack_bits = 0;
            end
        end
    endfunction

    // Random filler bits may leave an unfinished token at the stream end.
    function automatic void close_stream();
        if (pack_bits > 0) put_field($urandom_range(0, 255), 8 - pack_bits);
    endfunction

    function automatic int unsigned pick_width(input int unsigned widest);
        case ($urandom_range(0, 3))
            0:       return 1;
            1:       return widest;
            default: return $urandom_range(1, widest);
        endcase
    endfunction

    // A reachable distance, or on request one that the decoder must reject where the stream allows one.
    function automatic int unsigned pick_distance(input int unsigned farthest,
                                                  input logic flag, input bit broken);
        if (broken) begin
            if (flag && $urandom_range(0, 1)) return 0;
            if (decoded_so_far < farthest) return $urandom_range(decoded_so_far + 1, farthest);
            if (flag) return 0;
        end
        return $urandom_range(1, (decoded_so_far < farthest) ? decoded_so_far : farthest);
    endfunction

    function automatic void add_token(input int unsigned ow, input int unsigned lw,
                                      input logic flag);
        int unsigned farthest;
        int unsigned longest;
        int unsigned count;
        int unsigned choice;
        bit          broken;
        farthest = (1 << ow) - 1;
        longest  = (1 << lw) - 1;
        choice   = $urandom_range(0, 99);
        broken   = ($urandom_range(0, 39) == 0);
        count    = $urandom_range(0, longest);
        if ((choice < 40 || decoded_so_far == 0) && !broken) begin
            if (flag) begin
                put_field(1, 1);
                put_field($urandom_range(0, 255), lzd_pkg::LIT_BITS);
                decoded_so_far++;
            end else begin
                put_field(0, ow);
                put_field(count, lw);
                repeat (count) put_field($urandom_range(0, 255), lzd_pkg::LIT_BITS);
                decoded_so_far += count;
            end
        end else begin
            if (flag) put_field(0, 1);
            put_field(pick_distance(farthest, flag, broken), ow);
            put_field(count, lw);
            decoded_so_far += count;
        end
    endfunction

    // One input transaction; a new burst may start after a random gap.
    task automatic send_byte(input logic [7:0] data, input logic stream_end);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= stream_end;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_stream();
        int unsigned i;
        for (i = 0; i < stream_q.size(); i++) send_byte(stream_q[i], i == stream_q.size() - 1);
        streams_sent++;
        bytes_sent += stream_q.size();
    endtask

    // Output side: stretches of steady, random and regular stalls, with one
    // long hold-off so that the decoder backs up into its input.
    initial begin : result_receiver
        int unsigned cycle_count;
        int unsigned span;
        int unsigned mode;
        bit          held_off;
        cycle_count   = 0;
        held_off      = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            if (!held_off && cycle_count >= HOLD_OFF_START) begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                cycle_count += HOLD_OFF_CYCLES;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 60);
                repeat (span) begin
                    case (mode)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= ($urandom_range(0, 99) < 60);
                        2:       m_axis_tready <= (cycle_count % 4 != 3);
                        default: m_axis_tready <= ($urandom_range(0, 99) < 20);
                    endcase
                    @(posedge i_clk);
                    cycle_count++;
                end
            end
        end
    end

    // Watchdog.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding.", cycles, pending);
        $display("lz77_bitpacked_stream_decoder_unit: mismatch");
        $finish;
    end

    initial begin : stimulus
        int unsigned random_sent;
        int unsigned choice;
        int unsigned ow;
        int unsigned lw;
        int unsigned tokens;
        logic        flag;
        logic [7:0]  first;
        logic [7:0]  second;

        burst_left    = 0;
        streams_sent  = 0;
        bytes_sent    = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A stream that ends on its first header byte.
        stream_q.delete();
        append_byte(8'h05);
        send_stream();

        // Offset width of zero; the following bytes are dropped.
        open_stream(8'h00, 8'h03);
        append_byte(8'h55);
        append_byte(8'hAA);
        send_stream();

        // Every header bit set: both widths far too large.
        open_stream(8'hFF, 8'hFF);
        send_stream();

        // Widest offset in flag mode, length one beyond the limit.
        open_stream(8'h8C, 8'h06);
        send_stream();

        // Flag mode: literals at both extremes, an overlapping copy, then a
        // copy with offset zero, which is an error; a dropped byte follows.
        open_stream(8'h82, 8'h02);
        put_field(1, 1);
        put_field(8'h00, lzd_pkg::LIT_BITS);
        put_field(1, 1);
        put_field(8'hFF, lzd_pkg::LIT_BITS);
        put_field(0, 1);
        put_field(1, 2);
        put_field(3, 2);
        put_field(0, 1);
        put_field(0, 2);
        put_field(2, 2);
        close_stream();
        append_byte(8'hA5);
        send_stream();

        // Run mode: a literal run, an empty run, an empty copy, an
        // overlapping copy, then an offset beyond the bytes produced.
        open_stream(8'h03, 8'h03);
        put_field(0, 3);
        put_field(2, 3);
        put_field(8'h5A, lzd_pkg::LIT_BITS);
        put_field(8'hC3, lzd_pkg::LIT_BITS);
        put_field(0, 3);
        put_field(0, 3);
        put_field(1, 3);
        put_field(0, 3);
        put_field(2, 3);
        put_field(3, 3);
        put_field(6, 3);
        put_field(1, 3);
        close_stream();
        send_stream();

        // Random streams, mostly well formed with the odd broken token.
        random_sent = 0;
        while (random_sent < RANDOM_BYTES) begin
            choice = $urandom_range(0, 99);
            if (choice < 78) begin
                ow     = pick_width(MAX_OFFSET_BITS);
                lw     = pick_width(MAX_LENGTH_BITS);
                flag   = 1'($urandom_range(0, 1));
                first  = {flag, ow[6:0]};
                second = lw[7:0];
                open_stream(first, second);
                tokens = $urandom_range(1, 10);
                repeat (tokens) add_token(ow, lw, flag);
                close_stream();
            end else if (choice < 88) begin
                // Header with at least one width out of range.
                flag = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 3))
                    0: begin
                        first  = {flag, 7'd0};
                        second = 8'($urandom_range(0, 255));
                    end
                    1: begin
                        ow     = $urandom_range(MAX_OFFSET_BITS + 1, 127);
                        first  = {flag, ow[6:0]};
                        second = 8'($urandom_range(0, 255));
                    end
                    2: begin
                        first  = {flag, 7'd1};
                        second = 8'd0;
                    end
                    default: begin
                        ow     = $urandom_range(1, MAX_OFFSET_BITS);
                        first  = {flag, ow[6:0]};
                        second = 8'($urandom_range(MAX_LENGTH_BITS + 1, 255));
                    end
                endcase
                open_stream(first, second);
                repeat ($urandom_range(0, 3)) append_byte(8'($urandom_range(0, 255)));
            end else if (choice < 94) begin
                stream_q.delete();
                append_byte(8'($urandom_range(0, 255)));
            end else begin
                // Noise: whatever the bytes happen to mean.
                stream_q.delete();
                repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
            end
            send_stream();
            random_sent += stream_q.size();
        end
        s_axis_tvalid <= 1'b0;

        // Let every owed result arrive, then watch for strays.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Decoded %0d streams from %0d compressed bytes; %0d results checked.",
                 streams_sent, bytes_sent, result_count);
        $display("Flag and run modes, %0d header or offset errors, and a long output stall.",
                 error_count);
        if (fail_count == 0) begin
            $display("lz77_bitpacked_stream_decoder_unit: match");
        end else begin
            $display("lz77_bitpacked_stream_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
src/lzd_pkg.sv
src/lzd_history.sv
src/lzd_outq.sv
src/lzd_seq.sv
src/lz77_bitpacked_stream_decoder_unit.sv
tb/lz77_decoder_stream_checker.sv
tb/lz77_bitpacked_stream_decoder_unit_test.sv
